// ===== src/frta_pkg.sv =====
package frta_pkg;

	localparam logic [31:0] ADDR_LIMIT = 32'hFFFF_F000;
	localparam logic [31:0] PAGE_MASK  = 32'h0000_0FFF;
	localparam logic [31:0] PAGE_BYTES = 32'h0000_1000;

	typedef enum logic [1:0] {
		CMD_ADD       = 2'd0,
		CMD_CUT       = 2'd1,
		CMD_ALLOC_LOW = 2'd2,
		CMD_ALLOC_PG  = 2'd3
	} frta_cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SLOT  = 2'd1,
		ST_NO_FIT   = 2'd2,
		ST_ZERO_LEN = 2'd3
	} frta_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_PREP,
		S_ADD_PASS,
		S_PIECE,
		S_CUT_PASS,
		S_LOW_PASS,
		S_PAGE_FIND,
		S_PAGE_FIX,
		S_FIN
	} frta_state_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] len;
	} frta_entry_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] base;
		logic [31:0] len;
	} frta_prep_t;

	// Clips a range at the address limit and trims it to whole pages.
	function automatic frta_prep_t add_prep(input logic [63:0] addr, input logic [63:0] len);
		frta_prep_t  p;
		logic [63:0] room;
		logic [63:0] l;
		room   = {32'b0, ADDR_LIMIT} - addr;
		l      = (len > room) ? room : len;
		p.base = (addr[31:0] + PAGE_MASK) & ~PAGE_MASK;
		p.len  = l[31:0] & ~PAGE_MASK;
		p.ok   = (addr <= {32'b0, ADDR_LIMIT}) && (p.len != 32'b0);
		return p;
	endfunction

endpackage

// ===== src/frta_cell.sv =====
module frta_cell
	import frta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift,
	input  frta_entry_t nxt,
	output frta_entry_t cur
);

	frta_entry_t cur_q;

	// One table slot; on a shift it takes the entry of its neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (shift) begin
			cur_q <= nxt;
		end
	end

	assign cur = cur_q;

endmodule

// ===== src/free_range_table_allocator.sv =====
// Free physical range table allocator.
//
// Items arrive on the s_ channel: s_tuser carries the command (add, cut,
// allocate lowest, allocate page) and s_tdata the start, length and end.
// Each item yields exactly one result item on the m_ channel, carrying the
// allocated address, a status code and the table counters after the command.
//
// The table lives in a ring of TABLE_SLOTS cells. While a command runs the
// ring rotates one slot per cycle and the controller inspects or rewrites
// the entry passing the head; a full revolution leaves the ring aligned
// again. One item is worked on at a time. Add prepares the range, then
// makes one pass. Allocate page makes a find pass and a fix pass. Cut
// makes passes until no overlapping entry is left and re-adds the pieces
// it cut off; allocate lowest makes a search pass before its cut.
// Zero or oversized allocate-lowest requests go straight to the result.
// The result sits in an output register; when the receiver stalls, the
// block finishes the next item's work and then waits for that register.
// Reset clears the whole table and all counters at once.
module free_range_table_allocator
	import frta_pkg::*;
#(
	parameter int TABLE_SLOTS = 32,
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1),
	localparam int OUT_W = ((98 + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [159:0]     s_tdata,  // range_start[63:0], range_length[63:0], range_end[31:0]
	input  logic [1:0]       s_tuser,  // command[1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // result_address, status, entries_used, highest_end,
	                                   // allocated_total, zero pad
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int PAD_W = OUT_W - (98 + CNT_W);

	frta_state_t state_q, state_d;

	frta_entry_t ring [TABLE_SLOTS];
	frta_entry_t head, head_wr;
	logic        shift;
	logic [IDX_W-1:0] rot_q;
	logic [CNT_W-1:0] rot_ext;
	logic        in_tbl, last;

	frta_cmd_t    cmd_q, cmd_d;
	frta_status_t status_q, status_d;
	logic [31:0]  result_q, result_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [31:0]  high_q, high_d, bytes_q, bytes_d;

	logic [63:0]  add_addr_q, add_addr_d, add_len_q, add_len_d;
	logic [31:0]  add_base_q, add_base_d, add_len32_q, add_len32_d;
	logic         add_done_q, add_done_d, in_cut_q, in_cut_d;
	frta_prep_t   prep;

	logic [63:0]  cut_lo_q, cut_lo_d;
	logic [33:0]  cut_hi_q, cut_hi_d;
	logic [CNT_W-1:0] m_q, m_d;
	logic         hit_q, hit_d;
	logic         pc1_v_q, pc1_v_d, pc2_v_q, pc2_v_d;
	logic [32:0]  pc1_a_q, pc1_a_d, pc1_l_q, pc1_l_d, pc2_a_q, pc2_a_d, pc2_l_q, pc2_l_d;

	logic [32:0]  need_q, need_d;
	logic         low_found_q, low_found_d;
	logic [31:0]  low_base_q, low_base_d, low_final;
	logic         page_found_q, page_found_d;
	logic [IDX_W-1:0] page_idx_q, page_idx_d;

	logic         out_load, m_tvalid_q;
	logic [31:0]  o_result_q, o_high_q, o_bytes_q;
	frta_status_t o_status_q;
	logic [CNT_W-1:0] o_cnt_q;

	logic [32:0]  mem_hi;
	logic [63:0]  lo64;
	logic [33:0]  hi34;
	logic         overlap;
	logic         add_hit, cut_hit, low_take, page_take, page_fix;
	logic [31:0]  page_len;
	logic         accept, req_zero, req_huge;

	// Ring of slot cells; the head entry re-enters at the tail.
	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		frta_entry_t nxt;
		if (i == TABLE_SLOTS - 1) begin : g_tail
			assign nxt = head_wr;
		end else begin : g_mid
			assign nxt = ring[i+1];
		end
		frta_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.nxt    (nxt),
			.cur    (ring[i])
		);
	end

	assign head    = ring[0];
	assign rot_ext = CNT_W'(rot_q);
	assign in_tbl  = rot_ext < cnt_q;
	assign last    = rot_q == IDX_W'(TABLE_SLOTS - 1);
	assign shift   = (state_q == S_ADD_PASS) || (state_q == S_CUT_PASS) ||
	                 (state_q == S_LOW_PASS) || (state_q == S_PAGE_FIND) ||
	                 (state_q == S_PAGE_FIX);

	assign accept   = s_tvalid && s_tready;
	assign s_tready = state_q == S_IDLE;
	assign req_zero = s_tdata[127:64] == 64'b0;
	assign req_huge = s_tdata[127:96] != 32'b0;
	assign prep     = add_prep(add_addr_q, add_len_q);

	// Overlap of the head entry with the span being cut.
	assign mem_hi  = {1'b0, head.base} + {1'b0, head.len};
	assign lo64    = (cut_lo_q > {32'b0, head.base}) ? cut_lo_q : {32'b0, head.base};
	assign hi34    = (cut_hi_q < {1'b0, mem_hi}) ? cut_hi_q : {1'b0, mem_hi};
	assign overlap = {30'b0, hi34} > lo64;

	assign add_hit   = (state_q == S_ADD_PASS) && !add_done_q && (head.len == 32'b0);
	assign cut_hit   = (state_q == S_CUT_PASS) && !hit_q && (rot_ext >= m_q) && in_tbl && overlap;
	assign low_take  = (state_q == S_LOW_PASS) && in_tbl && ({1'b0, head.len} >= need_q) &&
	                   (!low_found_q || (head.base < low_base_q));
	assign page_take = (state_q == S_PAGE_FIND) && in_tbl && (head.len != 32'b0);
	assign page_fix  = (state_q == S_PAGE_FIX) && (rot_q == page_idx_q);
	assign page_len  = (head.len < PAGE_BYTES) ? 32'b0 : head.len - PAGE_BYTES;
	assign low_final = low_take ? head.base : low_base_q;
	assign out_load  = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (frta_cmd_t'(s_tuser))
						CMD_ADD:       state_d = S_ADD_PREP;
						CMD_CUT:       state_d = S_CUT_PASS;
						CMD_ALLOC_LOW: state_d = (req_zero || req_huge) ? S_FIN : S_LOW_PASS;
						CMD_ALLOC_PG:  state_d = S_PAGE_FIND;
						default:       state_d = S_IDLE;
					endcase
				end
			end
			S_ADD_PREP:  state_d = prep.ok ? S_ADD_PASS : (in_cut_q ? S_PIECE : S_FIN);
			S_ADD_PASS:  if (last) state_d = in_cut_q ? S_PIECE : S_FIN;
			S_PIECE:     state_d = (pc1_v_q || pc2_v_q) ? S_ADD_PREP : S_CUT_PASS;
			S_CUT_PASS:  if (last) state_d = (hit_q || cut_hit) ? S_PIECE : S_FIN;
			S_LOW_PASS:  if (last) state_d = (low_found_q || low_take) ? S_CUT_PASS : S_FIN;
			S_PAGE_FIND: if (last) state_d = (page_found_q || page_take) ? S_PAGE_FIX : S_FIN;
			S_PAGE_FIX:  if (last) state_d = S_FIN;
			S_FIN:       if (out_load) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Datapath and head rewrite for each state.
	always_comb begin
		head_wr      = head;
		cmd_d        = cmd_q;
		status_d     = status_q;
		result_d     = result_q;
		cnt_d        = cnt_q;
		high_d       = high_q;
		bytes_d      = bytes_q;
		add_addr_d   = add_addr_q;
		add_len_d    = add_len_q;
		add_base_d   = add_base_q;
		add_len32_d  = add_len32_q;
		add_done_d   = add_done_q;
		in_cut_d     = in_cut_q;
		cut_lo_d     = cut_lo_q;
		cut_hi_d     = cut_hi_q;
		m_d          = m_q;
		hit_d        = hit_q;
		pc1_v_d      = pc1_v_q;
		pc1_a_d      = pc1_a_q;
		pc1_l_d      = pc1_l_q;
		pc2_v_d      = pc2_v_q;
		pc2_a_d      = pc2_a_q;
		pc2_l_d      = pc2_l_q;
		need_d       = need_q;
		low_found_d  = low_found_q;
		low_base_d   = low_base_q;
		page_found_d = page_found_q;
		page_idx_d   = page_idx_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_d        = frta_cmd_t'(s_tuser);
					status_d     = ST_OK;
					result_d     = 32'b0;
					in_cut_d     = 1'b0;
					hit_d        = 1'b0;
					m_d          = '0;
					pc1_v_d      = 1'b0;
					pc2_v_d      = 1'b0;
					low_found_d  = 1'b0;
					page_found_d = 1'b0;
					add_addr_d   = s_tdata[63:0];
					add_len_d    = s_tdata[127:64];
					cut_lo_d     = s_tdata[63:0] & ~{32'b0, PAGE_MASK};
					cut_hi_d     = ({2'b0, s_tdata[159:128]} + {2'b0, PAGE_MASK}) &
					               ~{2'b0, PAGE_MASK};
					need_d       = ({1'b0, s_tdata[95:64]} + {1'b0, PAGE_MASK}) &
					               ~{1'b0, PAGE_MASK};
					if (frta_cmd_t'(s_tuser) == CMD_ALLOC_LOW) begin
						if (req_zero) begin
							status_d = ST_ZERO_LEN;
						end else if (req_huge) begin
							status_d = ST_NO_FIT;
						end
					end
				end
			end
			S_ADD_PREP: begin
				add_base_d  = prep.base;
				add_len32_d = prep.len;
				add_done_d  = 1'b0;
			end
			S_ADD_PASS: begin
				if (add_hit) begin
					head_wr.base = add_base_q;
					head_wr.len  = add_len32_q;
					add_done_d   = 1'b1;
					if (rot_ext >= cnt_q) begin
						cnt_d = rot_ext + CNT_W'(1);
					end
					if (add_base_q + add_len32_q > high_q) begin
						high_d = add_base_q + add_len32_q;
					end
				end else if (last && !add_done_q) begin
					status_d = ST_NO_SLOT;
				end
			end
			S_PIECE: begin
				in_cut_d = 1'b1;
				if (pc1_v_q) begin
					add_addr_d = {31'b0, pc1_a_q};
					add_len_d  = {31'b0, pc1_l_q};
					pc1_v_d    = 1'b0;
				end else if (pc2_v_q) begin
					add_addr_d = {31'b0, pc2_a_q};
					add_len_d  = {31'b0, pc2_l_q};
					pc2_v_d    = 1'b0;
				end else begin
					hit_d = 1'b0;
				end
			end
			S_CUT_PASS: begin
				if (cut_hit) begin
					head_wr = '0;
					hit_d   = 1'b1;
					m_d     = rot_ext + CNT_W'(1);
					pc1_v_d = lo64[32:0] > {1'b0, head.base};
					pc1_a_d = {1'b0, head.base};
					pc1_l_d = lo64[32:0] - {1'b0, head.base};
					pc2_v_d = hi34[32:0] < mem_hi;
					pc2_a_d = hi34[32:0];
					pc2_l_d = mem_hi - hi34[32:0];
				end else if (last && !hit_q && (cmd_q == CMD_ALLOC_LOW)) begin
					bytes_d  = bytes_q + need_q[31:0];
					result_d = low_base_q;
				end
			end
			S_LOW_PASS: begin
				if (low_take) begin
					low_base_d  = head.base;
					low_found_d = 1'b1;
				end
				if (last) begin
					cut_lo_d = {32'b0, low_final};
					cut_hi_d = ({2'b0, low_final} + {1'b0, need_q} + {2'b0, PAGE_MASK}) &
					           ~{2'b0, PAGE_MASK};
					if (!low_found_q && !low_take) begin
						status_d = ST_NO_FIT;
					end
				end
			end
			S_PAGE_FIND: begin
				if (page_take) begin
					page_idx_d   = rot_q;
					page_found_d = 1'b1;
				end else if (last && !page_found_q) begin
					status_d = ST_NO_FIT;
				end
			end
			S_PAGE_FIX: begin
				if (page_fix) begin
					head_wr.len = page_len;
					result_d    = head.base + page_len;
					bytes_d     = bytes_q + PAGE_BYTES;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rot_q      <= '0;
			cnt_q      <= '0;
			high_q     <= '0;
			bytes_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			high_q     <= high_d;
			bytes_q    <= bytes_d;
			m_tvalid_q <= (m_tvalid_q && !m_tready) || out_load;
			if (shift) begin
				rot_q <= last ? '0 : rot_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		status_q     <= status_d;
		result_q     <= result_d;
		add_addr_q   <= add_addr_d;
		add_len_q    <= add_len_d;
		add_base_q   <= add_base_d;
		add_len32_q  <= add_len32_d;
		add_done_q   <= add_done_d;
		in_cut_q     <= in_cut_d;
		cut_lo_q     <= cut_lo_d;
		cut_hi_q     <= cut_hi_d;
		m_q          <= m_d;
		hit_q        <= hit_d;
		pc1_v_q      <= pc1_v_d;
		pc1_a_q      <= pc1_a_d;
		pc1_l_q      <= pc1_l_d;
		pc2_v_q      <= pc2_v_d;
		pc2_a_q      <= pc2_a_d;
		pc2_l_q      <= pc2_l_d;
		need_q       <= need_d;
		low_found_q  <= low_found_d;
		low_base_q   <= low_base_d;
		page_found_q <= page_found_d;
		page_idx_q   <= page_idx_d;
		if (out_load) begin
			o_result_q <= result_q;
			o_status_q <= status_q;
			o_cnt_q    <= cnt_q;
			o_high_q   <= high_q;
			o_bytes_q  <= bytes_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, o_bytes_q, o_high_q, o_cnt_q, o_status_q, o_result_q};

endmodule

// ===== src/frta_checker.sv =====
module frta_checker
	import frta_pkg::*;
#(
	parameter int TABLE_SLOTS = 32,
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1),
	localparam int OUT_W = ((98 + CNT_W + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	logic [31:0]      res;
	logic [1:0]       sts;
	logic [CNT_W-1:0] used;
	logic [31:0]      high;

	assign res  = m_tdata[31:0];
	assign sts  = m_tdata[33:32];
	assign used = m_tdata[34 +: CNT_W];
	assign high = m_tdata[34 + CNT_W +: 32];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	// A failed allocation (no fit or zero length) returns address zero.
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((sts == ST_NO_FIT) || (sts == ST_ZERO_LEN)) |-> res == 32'b0)
		else $error("failed command returned an address");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> used <= CNT_W'(TABLE_SLOTS))
		else $error("entry count beyond table size");

	a_high_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> high[11:0] == 12'b0)
		else $error("highest end not page aligned");

endmodule

bind free_range_table_allocator frta_checker #(.TABLE_SLOTS(TABLE_SLOTS)) u_frta_checker (.*);
